FILE: hw/rtl/plbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plbs_pkg: shared definitions for the priority LED blink sequencer
// Mode, request and register codes, reset values and the state, settings
// and result structures used by the step logic and the top level.
// ----------------------------------------------------------------------------
package plbs_pkg;

  // Modes, also used as pattern codes in requests.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_CARD   = 2'd1;
  localparam logic [1:0] MODE_ALARM  = 2'd2;

  // Pending bit masks.
  localparam logic [1:0] BIT_CARD  = 2'b01;
  localparam logic [1:0] BIT_ALARM = 2'b10;

  // Request kinds.
  localparam logic [1:0] KIND_SET     = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_SERVICE = 2'd2;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_CARD_ON     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CARD_OFF    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_ON    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_OFF   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CARD_COUNT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_COUNT = 3'd5;

  // Register reset values.
  localparam logic [15:0] CARD_ON_RESET     = 16'd0;
  localparam logic [15:0] CARD_OFF_RESET    = 16'd25;
  localparam logic [15:0] ALARM_ON_RESET    = 16'd62;
  localparam logic [15:0] ALARM_OFF_RESET   = 16'd375;
  localparam logic [15:0] CARD_COUNT_RESET  = 16'd1;
  localparam logic [15:0] ALARM_COUNT_RESET = 16'd20;

  typedef struct packed {
    logic [15:0] card_on_ticks;
    logic [15:0] card_off_ticks;
    logic [15:0] alarm_on_ticks;
    logic [15:0] alarm_off_ticks;
    logic [15:0] card_blink_count;
    logic [15:0] alarm_blink_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  pending_bits;
    logic [1:0]  current_mode;
    logic [15:0] blinks_left;
    logic [15:0] saved_card;
    logic [15:0] saved_alarm;
    logic [15:0] phase_ticks;
    logic        phase_on;
    logic [1:0]  last_blink_mode;
    logic        led_pin;
  } state_t;

  localparam state_t STATE_RESET = '{
    pending_bits:    2'b00,
    current_mode:    MODE_NORMAL,
    blinks_left:     16'd0,
    saved_card:      16'd0,
    saved_alarm:     16'd0,
    phase_ticks:     16'd0,
    phase_on:        1'b1,
    last_blink_mode: MODE_NORMAL,
    led_pin:         1'b1
  };

  typedef struct packed {
    logic       led_level;
    logic [1:0] active_mode;
    logic       pattern_done;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/plbs_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plbs_channels: valid/ready channels of the blink sequencer
// Request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface plbs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] pattern;
  logic       tick;
  modport source (output valid, output kind, output pattern, output tick, input ready);
  modport sink (input valid, input kind, input pattern, input tick, output ready);
endinterface

interface plbs_res_if;
  logic       valid;
  logic       ready;
  logic       led_level;
  logic [1:0] active_mode;
  logic       pattern_done;
  modport source (output valid, output led_level, output active_mode, output pattern_done,
                  input ready);
  modport sink (input valid, input led_level, input active_mode, input pattern_done,
                output ready);
endinterface

interface plbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/priority_led_blink_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_led_blink_sequencer: LED driver with two prioritised blink patterns
//
// Requests arrive on the cmd channel (set, clear or service pass with tick)
// and each produces exactly one transaction on the res channel carrying the
// LED level, the active mode and a pattern-done flag.
// The result of an accepted request is registered as the request is taken.
// Throughput is one request per cycle; the whole update is one pass of
// the step logic between the state registers and the result register,
// so cmd.ready stays high as long as the result register is empty or is
// being taken in the same cycle.
// When the receiver stalls, the result is held and cmd.ready falls until it
// is taken; no request is lost.
// The cfg channel writes the six 16-bit tick and blink-count registers and is
// always ready; indexes beyond the last register are ignored. Writes are
// expected only while no request is in flight.
// Reset (rst, synchronous) restores the register defaults, clears all pending
// patterns, selects normal mode with the LED lit and empties the result.
// ----------------------------------------------------------------------------
module priority_led_blink_sequencer (
  input wire logic clk,
  input wire logic rst,
  plbs_cfg_if.sink cfg,
  plbs_cmd_if.sink cmd,
  plbs_res_if.source res
);
  import plbs_pkg::*;

  cfg_t    regs;
  state_t  state;
  state_t  state_next;
  result_t result_next;
  result_t result;
  logic    res_valid;
  logic    cmd_take;

  assign cfg.ready = 1'b1;
  assign cmd.ready = !res_valid || res.ready;
  assign cmd_take  = cmd.valid && cmd.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.card_on_ticks     <= CARD_ON_RESET;
      regs.card_off_ticks    <= CARD_OFF_RESET;
      regs.alarm_on_ticks    <= ALARM_ON_RESET;
      regs.alarm_off_ticks   <= ALARM_OFF_RESET;
      regs.card_blink_count  <= CARD_COUNT_RESET;
      regs.alarm_blink_count <= ALARM_COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CARD_ON:     regs.card_on_ticks     <= cfg.data;
        REG_CARD_OFF:    regs.card_off_ticks    <= cfg.data;
        REG_ALARM_ON:    regs.alarm_on_ticks    <= cfg.data;
        REG_ALARM_OFF:   regs.alarm_off_ticks   <= cfg.data;
        REG_CARD_COUNT:  regs.card_blink_count  <= cfg.data;
        REG_ALARM_COUNT: regs.alarm_blink_count <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Next-state logic for one request.
  plbs_step u_step (
    .cur     (state),
    .regs    (regs),
    .kind    (cmd.kind),
    .pattern (cmd.pattern),
    .tick    (cmd.tick),
    .nxt     (state_next),
    .res     (result_next)
  );

  // Sequencer state advances on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (cmd_take) begin
      state <= state_next;
    end
  end

  // Result register with its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      result <= result_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.led_level    = result.led_level;
  assign res.active_mode  = result.active_mode;
  assign res.pattern_done = result.pattern_done;

endmodule
`default_nettype wire

FILE: hw/rtl/plbs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plbs_step: next-state logic of the blink sequencer
// Applies one set, clear or service request to the current state and
// produces the next state together with the result of the request.
// ----------------------------------------------------------------------------
module plbs_step (
  input  var plbs_pkg::state_t  cur,
  input  var plbs_pkg::cfg_t    regs,
  input  wire logic [1:0]       kind,
  input  wire logic [1:0]       pattern,
  input  wire logic             tick,
  output var plbs_pkg::state_t  nxt,
  output var plbs_pkg::result_t res
);
  import plbs_pkg::*;

  state_t      s;
  logic        done;
  logic [15:0] old_ticks;
  logic [15:0] on_thr;
  logic [15:0] off_thr;

  // Applies one request; card or alarm thresholds follow the new mode.
  always_comb begin
    s         = cur;
    done      = 1'b0;
    old_ticks = 16'd0;
    on_thr    = regs.card_on_ticks;
    off_thr   = regs.card_off_ticks;

    case (kind)
      KIND_SET: begin
        // A set request of the pattern already running is ignored.
        if (pattern != cur.current_mode) begin
          if (pattern == MODE_CARD) begin
            s.pending_bits = s.pending_bits | BIT_CARD;
            s.saved_card   = regs.card_blink_count;
          end else if (pattern == MODE_ALARM) begin
            s.pending_bits = s.pending_bits | BIT_ALARM;
            s.saved_alarm  = regs.alarm_blink_count;
          end
        end
      end
      KIND_CLEAR: begin
        if (pattern == MODE_CARD) begin
          s.pending_bits = s.pending_bits & ~BIT_CARD;
        end else if (pattern == MODE_ALARM) begin
          s.pending_bits = s.pending_bits & ~BIT_ALARM;
        end
      end
      KIND_SERVICE: begin
        // Keep the running alarm count so that an interrupted alarm resumes.
        if (s.current_mode == MODE_ALARM) begin
          s.saved_alarm = s.blinks_left;
        end

        // Mode selection by priority.
        if ((s.pending_bits & BIT_CARD) != 2'b00) begin
          s.current_mode = MODE_CARD;
          if (s.saved_card != 16'd0) begin
            s.blinks_left = s.saved_card;
            s.saved_card  = 16'd0;
          end
        end else if ((s.pending_bits & BIT_ALARM) != 2'b00) begin
          if (s.current_mode != MODE_ALARM) begin
            s.blinks_left = s.saved_alarm;
          end
          s.current_mode = MODE_ALARM;
        end else begin
          s.current_mode = MODE_NORMAL;
        end

        if (s.current_mode == MODE_ALARM) begin
          on_thr  = regs.alarm_on_ticks;
          off_thr = regs.alarm_off_ticks;
        end

        if (s.current_mode == MODE_NORMAL) begin
          s.led_pin = 1'b1;
        end else begin
          // A change of blink mode restarts the phase.
          if (s.last_blink_mode != s.current_mode) begin
            s.phase_ticks     = 16'd0;
            s.phase_on        = 1'b1;
            s.last_blink_mode = s.current_mode;
          end
          if (tick) begin
            if (s.blinks_left == 16'd0) begin
              // Pattern exhausted: drop its pending mark.
              s.phase_ticks = 16'd0;
              done          = 1'b1;
              if (s.current_mode == MODE_CARD) begin
                s.pending_bits = s.pending_bits & ~BIT_CARD;
              end else begin
                s.pending_bits = s.pending_bits & ~BIT_ALARM;
              end
            end else begin
              old_ticks     = s.phase_ticks;
              s.phase_ticks = s.phase_ticks + 16'd1;
              if (s.phase_on) begin
                s.led_pin = 1'b1;
                if (old_ticks > on_thr) begin
                  s.phase_on    = 1'b0;
                  s.phase_ticks = 16'd0;
                end
              end else begin
                s.led_pin = 1'b0;
                if (old_ticks > off_thr) begin
                  s.phase_on    = 1'b1;
                  s.blinks_left = s.blinks_left - 16'd1;
                  s.phase_ticks = 16'd0;
                end
              end
            end
          end
        end
      end
      default: begin
        // Unused kind: state is left as it is.
      end
    endcase

    nxt              = s;
    res.led_level    = s.led_pin;
    res.active_mode  = s.current_mode;
    res.pattern_done = done;
  end

endmodule
`default_nettype wire

FILE: bench/tb_priority_led_blink_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_led_blink_sequencer: self-checking bench for the LED sequencer
// Drives set, clear and service requests with bursty valid and a stalling
// receiver. A cycle-free model of the sequencer predicts each result, and
// every result transaction is compared with the oldest prediction. Register
// settings change between phases only while the block is idle.
// ----------------------------------------------------------------------------
module tb_priority_led_blink_sequencer;
  import plbs_pkg::*;

  // Codes that the package leaves unnamed but the fields allow.
  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam logic [1:0] PATTERN_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // Receiver stall styles.
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] pattern;
    logic       tick;
  } led_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  plbs_cfg_if cfg_ch ();
  plbs_cmd_if cmd_ch ();
  plbs_res_if res_ch ();

  priority_led_blink_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model copy of the registers.
  logic [15:0] r_card_on, r_card_off, r_alarm_on, r_alarm_off, r_card_cnt, r_alarm_cnt;

  // Model copy of the sequencer state.
  logic [1:0]  m_pend, m_mode, m_last;
  logic [15:0] m_blinks, m_saved_card, m_saved_alarm, m_phase;
  logic        m_phase_lit, m_led;

  result_t led_status_q[$];
  result_t want_res;
  int      failures = 0;
  int      burst_left = 0;

  // Reports the first ten failures in full and counts the rest.
  function automatic void log_failure(input string msg);
    if (failures < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    failures++;
  endfunction

  // Moves the on/off phase of the running pattern; returns 1 when it is used up.
  function automatic bit advance_phase(input logic [15:0] on_thr, input logic [15:0] off_thr,
                                       input logic tk);
    logic [15:0] prev;
    if (m_last != m_mode) begin
      m_phase = 16'd0;
      m_phase_lit = 1'b1;
      m_last = m_mode;
    end
    if (!tk) return 1'b0;
    if (m_blinks == 16'd0) begin
      m_phase = 16'd0;
      return 1'b1;
    end
    prev = m_phase;
    m_phase = m_phase + 16'd1;
    if (m_phase_lit) begin
      m_led = 1'b1;
      if (prev > on_thr) begin
        m_phase_lit = 1'b0;
        m_phase = 16'd0;
      end
    end else begin
      m_led = 1'b0;
      if (prev > off_thr) begin
        m_phase_lit = 1'b1;
        m_blinks = m_blinks - 16'd1;
        m_phase = 16'd0;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the model and returns the LED status it leads to.
  function automatic result_t predict_led_status(input led_request_t rq);
    result_t r;
    bit      finished;
    finished = 1'b0;
    case (rq.kind)
      KIND_SET: begin
        if (rq.pattern != m_mode) begin
          if (rq.pattern == MODE_CARD) begin
            m_pend = m_pend | BIT_CARD;
            m_saved_card = r_card_cnt;
          end else if (rq.pattern == MODE_ALARM) begin
            m_pend = m_pend | BIT_ALARM;
            m_saved_alarm = r_alarm_cnt;
          end
        end
      end
      KIND_CLEAR: begin
        if (rq.pattern == MODE_CARD) m_pend = m_pend & ~BIT_CARD;
        else if (rq.pattern == MODE_ALARM) m_pend = m_pend & ~BIT_ALARM;
      end
      KIND_SERVICE: begin
        // A running alarm keeps its count so that it can resume later.
        if (m_mode == MODE_ALARM) m_saved_alarm = m_blinks;
        if ((m_pend & BIT_CARD) != 2'b00) begin
          m_mode = MODE_CARD;
          if (m_saved_card != 16'd0) begin
            m_blinks = m_saved_card;
            m_saved_card = 16'd0;
          end
        end else if ((m_pend & BIT_ALARM) != 2'b00) begin
          if (m_mode != MODE_ALARM) m_blinks = m_saved_alarm;
          m_mode = MODE_ALARM;
        end else begin
          m_mode = MODE_NORMAL;
        end
        if (m_mode == MODE_CARD) begin
          if (advance_phase(r_card_on, r_card_off, rq.tick)) begin
            m_pend = m_pend & ~BIT_CARD;
            finished = 1'b1;
          end
        end else if (m_mode == MODE_ALARM) begin
          if (advance_phase(r_alarm_on, r_alarm_off, rq.tick)) begin
            m_pend = m_pend & ~BIT_ALARM;
            finished = 1'b1;
          end
        end else begin
          m_led = 1'b1;
        end
      end
      default: ;
    endcase
    r.led_level = m_led;
    r.active_mode = m_mode;
    r.pattern_done = finished;
    return r;
  endfunction

  function automatic led_request_t make_request(input logic [1:0] k, input logic [1:0] p,
                                                input logic tk);
    led_request_t rq;
    rq.kind = k;
    rq.pattern = p;
    rq.tick = tk;
    return rq;
  endfunction

  // Sends one request transaction; the sender works in bursts with gaps between.
  task automatic send_request(input led_request_t rq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk) cmd_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind <= rq.kind;
    cmd_ch.pattern <= rq.pattern;
    cmd_ch.tick <= rq.tick;
    do @(posedge clk); while (!cmd_ch.ready);
    led_status_q.push_back(predict_led_status(rq));
  endtask

  // Stops sending and waits, with a bound, until every result has been taken.
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk) cmd_ch.valid <= 1'b0;
    while (led_status_q.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (led_status_q.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", led_status_q.size()));
      led_status_q.delete();
    end
    repeat (2) @(posedge clk);
  endtask

  // Writes one register through the configuration channel.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_CARD_ON:     r_card_on = val;
      REG_CARD_OFF:    r_card_off = val;
      REG_ALARM_ON:    r_alarm_on = val;
      REG_ALARM_OFF:   r_alarm_off = val;
      REG_CARD_COUNT:  r_card_cnt = val;
      REG_ALARM_COUNT: r_alarm_cnt = val;
      default: ;
    endcase
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // Mostly short thresholds so that patterns finish, now and then a long one.
  function automatic logic [15:0] pick_threshold();
    if ($urandom_range(0, 19) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 4));
  endfunction

  function automatic logic [15:0] pick_count();
    if ($urandom_range(0, 29) == 0) return 16'hFFFF;
    return 16'($urandom_range(0, 3));
  endfunction

  // Mostly service passes with a tick, some set and clear requests, a little noise.
  function automatic led_request_t random_request();
    led_request_t rq;
    int           roll;
    roll = $urandom_range(0, 99);
    rq.kind = KIND_SERVICE;
    rq.pattern = 2'($urandom_range(0, 3));
    rq.tick = 1'($urandom_range(0, 1));
    if (roll < 62) begin
      rq.tick = 1'b1;
    end else if (roll < 72) begin
      rq.tick = 1'b0;
    end else if (roll < 84) begin
      rq.kind = KIND_SET;
      rq.pattern = 2'($urandom_range(MODE_CARD, MODE_ALARM));
    end else if (roll < 92) begin
      rq.kind = KIND_CLEAR;
      rq.pattern = 2'($urandom_range(MODE_CARD, MODE_ALARM));
    end else begin
      rq.kind = 2'($urandom_range(0, 3));
    end
    return rq;
  endfunction

  // Requests that change nothing, at the reset settings.
  task automatic test_idle_requests();
    send_request(make_request(KIND_UNUSED, PATTERN_UNUSED, 1'b1));
    send_request(make_request(KIND_SET, MODE_NORMAL, 1'b0));
    send_request(make_request(KIND_SET, PATTERN_UNUSED, 1'b1));
    send_request(make_request(KIND_CLEAR, PATTERN_UNUSED, 1'b0));
    send_request(make_request(KIND_CLEAR, MODE_NORMAL, 1'b1));
    send_request(make_request(KIND_SERVICE, MODE_NORMAL, 1'b0));
    send_request(make_request(KIND_SERVICE, PATTERN_UNUSED, 1'b1));
  endtask

  // Short blink settings, plus a write to an index beyond the last register.
  task automatic test_register_access();
    wait_idle();
    write_reg(REG_CARD_ON, 16'd0);
    write_reg(REG_CARD_OFF, 16'd1);
    write_reg(REG_ALARM_ON, 16'd1);
    write_reg(REG_ALARM_OFF, 16'd0);
    write_reg(REG_CARD_COUNT, 16'd1);
    write_reg(REG_ALARM_COUNT, 16'd2);
    write_reg(REG_UNUSED, 16'hA5C3);
  endtask

  // An alarm is interrupted by a card-read blink and then resumes.
  task automatic test_card_preempts_alarm();
    send_request(make_request(KIND_SET, MODE_ALARM, 1'b0));
    send_request(make_request(KIND_SERVICE, MODE_NORMAL, 1'b1));
    send_request(make_request(KIND_SERVICE, MODE_NORMAL, 1'b1));
    // Setting the pattern that is already running is ignored.
    send_request(make_request(KIND_SET, MODE_ALARM, 1'b1));
    send_request(make_request(KIND_SET, MODE_CARD, 1'b0));
    // A pass without a tick switches the mode but leaves the LED alone.
    send_request(make_request(KIND_SERVICE, MODE_NORMAL, 1'b0));
    repeat (7) send_request(make_request(KIND_SERVICE, MODE_NORMAL, 1'b1));
    send_request(make_request(KIND_CLEAR, MODE_ALARM, 1'b0));
    send_request(make_request(KIND_SERVICE, MODE_NORMAL, 1'b1));
  endtask

  // Random traffic over several register settings, the extremes among them.
  task automatic test_random_traffic();
    logic [15:0] vals[6];
    for (int p = 0; p < 9; p++) begin
      for (int i = 0; i < 6; i++) begin
        case (p)
          0:       vals[i] = 16'h0000;
          1:       vals[i] = 16'hFFFF;
          2:       vals[i] = 16'($urandom_range(0, 65535));
          default: vals[i] = (i < 4) ? pick_threshold() : pick_count();
        endcase
      end
      wait_idle();
      write_reg(REG_CARD_ON, vals[0]);
      write_reg(REG_CARD_OFF, vals[1]);
      write_reg(REG_ALARM_ON, vals[2]);
      write_reg(REG_ALARM_OFF, vals[3]);
      write_reg(REG_CARD_COUNT, vals[4]);
      write_reg(REG_ALARM_COUNT, vals[5]);
      repeat (110) send_request(random_request());
    end
  endtask

  // Receiver ready follows a pattern of its own: free, random or one in four.
  initial begin
    int style;
    int left;
    int cnt;
    res_ch.ready = 1'b0;
    style = STALL_NONE;
    left = 0;
    cnt = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = $urandom_range(STALL_NONE, STALL_PERIODIC);
        left = $urandom_range(16, 96);
      end
      left--;
      cnt++;
      case (style)
        STALL_NONE:   res_ch.ready <= 1'b1;
        STALL_RANDOM: res_ch.ready <= ($urandom_range(0, 1) == 1);
        default:      res_ch.ready <= (cnt % 4 == 0);
      endcase
    end
  end

  // Each result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (led_status_q.size() == 0) begin
        log_failure($sformatf("result with nothing predicted: led %0b mode %0d done %0b",
                              res_ch.led_level, res_ch.active_mode, res_ch.pattern_done));
      end else begin
        want_res = led_status_q.pop_front();
        if (res_ch.led_level !== want_res.led_level ||
            res_ch.active_mode !== want_res.active_mode ||
            res_ch.pattern_done !== want_res.pattern_done) begin
          log_failure($sformatf("expected led %0b mode %0d done %0b, got led %0b mode %0d done %0b",
                                want_res.led_level, want_res.active_mode, want_res.pattern_done,
                                res_ch.led_level, res_ch.active_mode, res_ch.pattern_done));
        end
      end
    end
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.kind = KIND_SET;
    cmd_ch.pattern = MODE_NORMAL;
    cmd_ch.tick = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CARD_ON;
    cfg_ch.data = 16'd0;
    r_card_on = CARD_ON_RESET;
    r_card_off = CARD_OFF_RESET;
    r_alarm_on = ALARM_ON_RESET;
    r_alarm_off = ALARM_OFF_RESET;
    r_card_cnt = CARD_COUNT_RESET;
    r_alarm_cnt = ALARM_COUNT_RESET;
    m_pend = STATE_RESET.pending_bits;
    m_mode = STATE_RESET.current_mode;
    m_blinks = STATE_RESET.blinks_left;
    m_saved_card = STATE_RESET.saved_card;
    m_saved_alarm = STATE_RESET.saved_alarm;
    m_phase = STATE_RESET.phase_ticks;
    m_phase_lit = STATE_RESET.phase_on;
    m_last = STATE_RESET.last_blink_mode;
    m_led = STATE_RESET.led_pin;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_idle_requests();
    test_register_access();
    test_card_preempts_alarm();
    test_random_traffic();

    wait_idle();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/plbs_pkg.sv
hw/rtl/plbs_channels.sv
hw/rtl/plbs_step.sv
hw/rtl/priority_led_blink_sequencer.sv
bench/tb_priority_led_blink_sequencer.sv
